>>> hw/rtl/chm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chm_pkg;
  localparam int Buckets = 256;
  localparam int PoolNodes = 256;
  localparam int NodeW = 8;
  localparam int PtrW = 9;
  localparam int CntW = 9;
  localparam logic [PtrW-1:0] NIL = 9'h1FF;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_HASH, S_MOD, S_HEAD_RD, S_HEAD_WAIT, S_INS_NEXT_RD, S_INS_NEXT_WAIT,
    S_INS_WR, S_NODE_RD, S_NODE_WAIT, S_NODE_CHK, S_REM_NEXT, S_REM_FREE, S_DONE
  } state_t;

  typedef struct packed {
    logic init_step;
    logic load;
    logic hash_step;
    logic mod_start;
    logic head_rd;
    logic free_next_rd;
    logic ins_wr;
    logic node_rd;
    logic advance;
    logic unlink;
    logic free_push;
    logic set_found;
    logic respond;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic hash_done;
    logic mod_done;
    logic pool_empty;
    logic node_nil;
    logic key_match;
    logic step_limit;
    logic [1:0] opcode;
  } sts_t;

  function automatic logic [31:0] mix_stage(input logic [2:0] s, input logic [31:0] d);
    logic [31:0] r;
    case (s)
      3'd0: r = (d + 32'h7ed55d16) + (d << 12);
      3'd1: r = (d ^ 32'hc761c23c) ^ (d >> 19);
      3'd2: r = (d + 32'h165667b1) + (d << 5);
      3'd3: r = (d + 32'hd3a2646c) ^ (d << 9);
      3'd4: r = (d + 32'hfd7046c5) + (d << 3);
      3'd5: r = (d ^ 32'hb55a4f09) ^ (d >> 16);
      default: r = d;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/chm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module chm_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire chm_pkg::sts_t sts,
  output chm_pkg::cmd_t cmd
);
  chm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= chm_pkg::S_INIT;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status = chm_pkg::ST_OK;
    busy = 1'b1;
    case (state_r)
      chm_pkg::S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_done) state_nxt = chm_pkg::S_IDLE;
      end
      chm_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = chm_pkg::S_HASH;
        end
      end
      chm_pkg::S_HASH: begin
        if (sts.opcode == chm_pkg::OP_INSERT && sts.pool_empty) begin
          cmd.respond = 1'b1;
          cmd.status = chm_pkg::ST_POOL_FULL;
          state_nxt = chm_pkg::S_DONE;
        end else if (sts.opcode != chm_pkg::OP_INSERT && sts.opcode != chm_pkg::OP_LOOKUP &&
                     sts.opcode != chm_pkg::OP_REMOVE) begin
          cmd.respond = 1'b1;
          state_nxt = chm_pkg::S_DONE;
        end else begin
          // The last mixing stage is applied by the modulo start.
          if (sts.hash_done) begin
            cmd.mod_start = 1'b1;
            state_nxt = chm_pkg::S_MOD;
          end else begin
            cmd.hash_step = 1'b1;
          end
        end
      end
      chm_pkg::S_MOD: begin
        if (sts.mod_done) state_nxt = chm_pkg::S_HEAD_RD;
      end
      chm_pkg::S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_nxt = chm_pkg::S_HEAD_WAIT;
      end
      chm_pkg::S_HEAD_WAIT: begin
        if (sts.opcode == chm_pkg::OP_INSERT) begin
          cmd.free_next_rd = 1'b1;
          state_nxt = chm_pkg::S_INS_NEXT_WAIT;
        end else begin
          state_nxt = chm_pkg::S_NODE_RD;
        end
      end
      chm_pkg::S_INS_NEXT_RD: begin
        cmd.free_next_rd = 1'b1;
        state_nxt = chm_pkg::S_INS_NEXT_WAIT;
      end
      chm_pkg::S_INS_NEXT_WAIT: begin
        cmd.free_next_rd = 1'b1;
        state_nxt = chm_pkg::S_INS_WR;
      end
      chm_pkg::S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        cmd.respond = 1'b1;
        state_nxt = chm_pkg::S_DONE;
      end
      chm_pkg::S_NODE_RD: begin
        if (sts.node_nil || sts.step_limit) begin
          cmd.respond = 1'b1;
          cmd.status = chm_pkg::ST_NOT_FOUND;
          state_nxt = chm_pkg::S_DONE;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt = chm_pkg::S_NODE_WAIT;
        end
      end
      chm_pkg::S_NODE_WAIT: state_nxt = chm_pkg::S_NODE_CHK;
      chm_pkg::S_NODE_CHK: begin
        if (sts.key_match) begin
          cmd.set_found = 1'b1;
          if (sts.opcode == chm_pkg::OP_REMOVE) begin
            state_nxt = chm_pkg::S_REM_NEXT;
          end else begin
            cmd.respond = 1'b1;
            state_nxt = chm_pkg::S_DONE;
          end
        end else begin
          cmd.advance = 1'b1;
          state_nxt = chm_pkg::S_NODE_RD;
        end
      end
      chm_pkg::S_REM_NEXT: begin
        cmd.unlink = 1'b1;
        state_nxt = chm_pkg::S_REM_FREE;
      end
      chm_pkg::S_REM_FREE: begin
        cmd.free_push = 1'b1;
        cmd.respond = 1'b1;
        state_nxt = chm_pkg::S_DONE;
      end
      chm_pkg::S_DONE: state_nxt = chm_pkg::S_IDLE;
      default: state_nxt = chm_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> hw/rtl/chm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module chm_dp (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [8:0] cfg_wdata,
  input  wire logic [1:0] in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_item_handle,
  input  wire chm_pkg::cmd_t cmd,
  output chm_pkg::sts_t sts,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [31:0] out_found_item,
  output logic [8:0] out_entry_count
);
  localparam int NW = chm_pkg::NodeW;
  localparam int PW = chm_pkg::PtrW;

  logic [PW-1:0] head_mem [chm_pkg::Buckets];
  logic [PW-1:0] next_mem [chm_pkg::PoolNodes];
  logic [31:0] key_mem [chm_pkg::PoolNodes];
  logic [31:0] item_mem [chm_pkg::PoolNodes];

  logic [8:0] bc_r;
  logic [1:0] op_r;
  logic [31:0] key_r, item_r, h_r, found_r;
  logic [2:0] hstep_r;
  logic [8:0] init_r;
  logic [PW-1:0] free_r, cur_r, prev_r, next_q, cur_next_r;
  logic [31:0] key_q, item_q;
  logic [7:0] bucket_r;
  logic [8:0] steps_r;
  logic [chm_pkg::CntW-1:0] held_r;
  // Restoring modulo: one quotient bit per cycle over the 32-bit hash.
  logic [8:0] rem_r;
  logic [5:0] mcnt_r;
  logic mbusy_r;
  logic [8:0] divisor;
  logic [9:0] rem_sh;

  always_comb begin
    divisor = bc_r;
    if (bc_r == 9'd0) divisor = 9'd1;
    if (bc_r > 9'(chm_pkg::Buckets)) divisor = 9'(chm_pkg::Buckets);
    rem_sh = {rem_r, h_r[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) bc_r <= 9'd256;
    else if (cfg_we) bc_r <= cfg_wdata;
  end

  // Clearing pass: after reset this writes all 256 empty heads and the free list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= '0;
    end else if (cmd.init_step && !init_r[8]) begin
      init_r <= init_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step && !init_r[8]) begin
      head_mem[init_r[7:0]] <= chm_pkg::NIL;
      next_mem[init_r[7:0]] <= (init_r[7:0] == 8'hFF) ? chm_pkg::NIL : init_r + 9'd1;
    end else begin
      if (cmd.ins_wr) begin
        head_mem[bucket_r] <= free_r;
      end else if (cmd.unlink && prev_r == chm_pkg::NIL) begin
        head_mem[bucket_r] <= cur_next_r;
      end
      // On an insert cur_r holds the old chain head.
      if (cmd.ins_wr) begin
        next_mem[free_r[NW-1:0]] <= cur_r;
      end else if (cmd.unlink && prev_r != chm_pkg::NIL) begin
        next_mem[prev_r[NW-1:0]] <= cur_next_r;
      end else if (cmd.free_push) begin
        next_mem[cur_r[NW-1:0]] <= free_r;
      end
    end
    if (cmd.ins_wr) begin
      key_mem[free_r[NW-1:0]] <= key_r;
      item_mem[free_r[NW-1:0]] <= item_r;
    end
    next_q <= next_mem[cmd.free_next_rd ? free_r[NW-1:0] : cur_r[NW-1:0]];
    key_q <= key_mem[cur_r[NW-1:0]];
    item_q <= item_mem[cur_r[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '0;
      held_r <= '0;
      mbusy_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.respond;
      if (cmd.ins_wr) begin
        free_r <= next_q;
        held_r <= held_r + 9'd1;
      end
      if (cmd.free_push) begin
        free_r <= cur_r;
        if (held_r != '0) held_r <= held_r - 9'd1;
      end
      if (cmd.mod_start) mbusy_r <= 1'b1;
      else if (mbusy_r && mcnt_r == 6'd31) mbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      key_r <= in_key;
      item_r <= in_item_handle;
      h_r <= in_key;
      hstep_r <= '0;
      found_r <= '0;
      steps_r <= '0;
      prev_r <= chm_pkg::NIL;
    end
    if (cmd.hash_step) begin
      h_r <= chm_pkg::mix_stage(hstep_r, h_r);
      hstep_r <= hstep_r + 3'd1;
    end
    if (cmd.mod_start) begin
      rem_r <= '0;
      mcnt_r <= '0;
      h_r <= chm_pkg::mix_stage(hstep_r, h_r);
    end else if (mbusy_r) begin
      h_r <= {h_r[30:0], 1'b0};
      mcnt_r <= mcnt_r + 6'd1;
      rem_r <= (rem_sh >= {1'b0, divisor}) ? 9'(rem_sh - {1'b0, divisor}) : rem_sh[8:0];
      if (mcnt_r == 6'd31) bucket_r <= (rem_sh >= {1'b0, divisor}) ?
                                       8'(rem_sh - {1'b0, divisor}) : 8'(rem_sh);
    end
    if (cmd.head_rd) cur_r <= head_mem[bucket_r];
    if (cmd.node_rd) steps_r <= steps_r + 9'd1;
    if (cmd.set_found) begin
      found_r <= item_q;
      cur_next_r <= next_q;
    end
    if (cmd.advance) begin
      prev_r <= cur_r;
      cur_r <= next_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_status <= cmd.status;
      out_found_item <= (cmd.status == chm_pkg::ST_OK && op_r != chm_pkg::OP_INSERT
                        && (cmd.set_found || cmd.free_push)) ?
                        (cmd.set_found ? item_q : found_r) : 32'd0;
    end
  end

  // The count reflects the update that lands together with the response.
  assign out_entry_count = held_r;

  always_comb begin
    sts.init_done = init_r[8];
    sts.hash_done = (hstep_r == 3'd5);
    sts.mod_done = mbusy_r && (mcnt_r == 6'd31);
    sts.pool_empty = (free_r == chm_pkg::NIL);
    sts.node_nil = (cur_r == chm_pkg::NIL);
    sts.key_match = (key_q == key_r);
    sts.step_limit = steps_r[8];
    sts.opcode = op_r;
  end
endmodule
`default_nettype wire

>>> hw/rtl/chained_hash_map_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Chained hash map of 256 nodes. Pulse start with busy low to issue one
// operation; exactly one result comes back as a one-cycle out_valid strobe and
// the receiver cannot stall it. After reset a clearing pass keeps busy high.
// An operation first mixes the key into a hash, runs a bit-serial modulo by
// the bucket count and reads the bucket head; an insert then reads the free
// list's next pointer and links the new node in, while a lookup or remove
// walks the chain node by node. A refused insert or the unused opcode is
// answered from the hash state without hashing. Busy drops in the cycle after
// the strobe.
module chained_hash_map_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] in_opcode,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_item_handle,
  input  wire logic cfg_we,
  input  wire logic [8:0] cfg_wdata,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [31:0] out_found_item,
  output logic [8:0] out_entry_count
);
  chm_pkg::cmd_t cmd;
  chm_pkg::sts_t sts;

  chm_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .sts, .cmd);

  chm_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_opcode, .in_key, .in_item_handle,
    .cmd, .sts, .out_valid, .out_status, .out_found_item, .out_entry_count
  );
endmodule
`default_nettype wire

>>> dv/tb_chained_hash_map_engine.sv
`timescale 1ns / 1ps
module tb_chained_hash_map_engine;

  typedef struct {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] item_handle;
    logic        is_cfg;
    logic [8:0]  cfg_value;
  } op_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] found_item;
    logic [8:0]  entry_count;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = '0;
  logic [31:0] in_key = '0;
  logic [31:0] in_item_handle = '0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_wdata = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [31:0] out_found_item;
  logic [8:0] out_entry_count;

  chained_hash_map_engine u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_key(in_key), .in_item_handle(in_item_handle),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status),
    .out_found_item(out_found_item), .out_entry_count(out_entry_count)
  );

  always #6 clk = ~clk;

  // Shadow copy of the table.
  logic [8:0]  sh_bucket_count;
  logic [8:0]  sh_heads [chm_pkg::Buckets];
  logic [8:0]  sh_next [chm_pkg::PoolNodes];
  logic [31:0] sh_keys [chm_pkg::PoolNodes];
  logic [31:0] sh_items [chm_pkg::PoolNodes];
  logic [8:0]  sh_free;
  logic [8:0]  sh_held;

  op_t   pending_ops[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    cycle_count = 0;
  bit    stim_done = 0;
  int    gap_left = 0;
  int    popped = 0;
  int    quiet_after = 0;

  function automatic logic [31:0] jenkins_mix(logic [31:0] d);
    d = (d + 32'h7ed55d16) + (d << 12);
    d = (d ^ 32'hc761c23c) ^ (d >> 19);
    d = (d + 32'h165667b1) + (d << 5);
    d = (d + 32'hd3a2646c) ^ (d << 9);
    d = (d + 32'hfd7046c5) + (d << 3);
    d = (d ^ 32'hb55a4f09) ^ (d >> 16);
    return d;
  endfunction

  function automatic int bucket_of(logic [31:0] key);
    int bc;
    bc = sh_bucket_count;
    if (bc == 0) bc = 1;
    if (bc > chm_pkg::Buckets) bc = chm_pkg::Buckets;
    return jenkins_mix(key) % bc;
  endfunction

  task automatic reset_shadow();
    sh_bucket_count = 9'd256;
    for (int i = 0; i < chm_pkg::Buckets; i++) sh_heads[i] = chm_pkg::NIL;
    for (int i = 0; i < chm_pkg::PoolNodes; i++) begin
      sh_next[i] = (i + 1 < chm_pkg::PoolNodes) ? 9'(i + 1) : chm_pkg::NIL;
      sh_keys[i] = '0;
      sh_items[i] = '0;
    end
    sh_free = '0;
    sh_held = '0;
  endtask

  task automatic apply_map_op(op_t o);
    resp_t r;
    int b;
    logic [8:0] n, prev;
    int steps;
    r.status = chm_pkg::ST_OK;
    r.found_item = '0;
    if (o.opcode == chm_pkg::OP_INSERT) begin
      if (sh_free >= chm_pkg::PoolNodes) begin
        r.status = chm_pkg::ST_POOL_FULL;
      end else begin
        b = bucket_of(o.key);
        n = sh_free;
        sh_free = sh_next[n];
        sh_keys[n] = o.key;
        sh_items[n] = o.item_handle;
        sh_next[n] = sh_heads[b];
        sh_heads[b] = n;
        sh_held++;
      end
    end else if (o.opcode == chm_pkg::OP_LOOKUP || o.opcode == chm_pkg::OP_REMOVE) begin
      b = bucket_of(o.key);
      n = sh_heads[b];
      prev = chm_pkg::NIL;
      steps = 0;
      r.status = chm_pkg::ST_NOT_FOUND;
      while (n < chm_pkg::PoolNodes && steps < chm_pkg::PoolNodes) begin
        if (sh_keys[n] == o.key) begin
          r.found_item = sh_items[n];
          r.status = chm_pkg::ST_OK;
          if (o.opcode == chm_pkg::OP_REMOVE) begin
            if (prev < chm_pkg::PoolNodes) sh_next[prev] = sh_next[n];
            else sh_heads[b] = sh_next[n];
            sh_next[n] = sh_free;
            sh_free = n;
            if (sh_held > 0) sh_held--;
          end
          break;
        end
        prev = n;
        n = sh_next[n];
        steps++;
      end
    end
    r.entry_count = sh_held;
    expected_resps.push_back(r);
  endtask

  task automatic queue_op(logic [1:0] opc, logic [31:0] k, logic [31:0] h);
    op_t o;
    o.opcode = opc; o.key = k; o.item_handle = h; o.is_cfg = 0; o.cfg_value = '0;
    pending_ops.push_back(o);
  endtask

  task automatic queue_cfg(logic [8:0] v);
    op_t o;
    o = '{default: '0};
    o.is_cfg = 1; o.cfg_value = v;
    pending_ops.push_back(o);
  endtask

  // Driver: a configuration write waits until every result is back, plus a pause.
  int cfg_wait = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else if (start && !busy) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      void'(pending_ops.pop_front());
      popped <= popped + 1;
      gap_left <= (popped < quiet_after) && ($urandom_range(0, 3) == 0) ?
                  $urandom_range(1, 9) : 0;
    end else if (cfg_we) begin
      cfg_we <= 1'b0;
      void'(pending_ops.pop_front());
      popped <= popped + 1;
    end else if (start) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
    end else if (pending_ops.size() > 0) begin
      if (pending_ops[0].is_cfg) begin
        if (expected_resps.size() == 0 && !busy) begin
          if (cfg_wait < 80) cfg_wait <= cfg_wait + 1;
          else begin
            cfg_wait <= 0;
            cfg_we <= 1'b1;
            cfg_wdata <= pending_ops[0].cfg_value;
            sh_bucket_count = pending_ops[0].cfg_value;
          end
        end
      end else begin
        start <= 1'b1;
        in_opcode <= pending_ops[0].opcode;
        in_key <= pending_ops[0].key;
        in_item_handle <= pending_ops[0].item_handle;
        apply_map_op(pending_ops[0]);
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_valid) begin
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result status=%0d item=%h count=%0d", $time,
                 out_status, out_found_item, out_entry_count);
        errors++;
      end else begin
        e = expected_resps.pop_front();
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_found_item !== e.found_item) begin
          $display("%0t: found_item expected %h actual %h", $time, e.found_item,
                   out_found_item);
          errors++;
        end
        if (out_entry_count !== e.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count,
                   out_entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 10000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key(logic [31:0] pool_keys[$]);
    if (pool_keys.size() > 0 && $urandom_range(0, 3) != 0)
      return pool_keys[$urandom_range(0, pool_keys.size() - 1)];
    return $urandom();
  endfunction

  initial begin
    logic [31:0] keys[$];
    logic [31:0] k;
    int r;
    reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, duplicates, no-op code, missing keys.
    queue_op(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
    queue_op(chm_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'h0);
    queue_op(chm_pkg::OP_INSERT, 32'h0, 32'hFFFFFFFF);
    queue_op(chm_pkg::OP_INSERT, 32'hFFFFFFFF, 32'h0);
    queue_op(chm_pkg::OP_INSERT, 32'h0, 32'hA5A5A5A5);
    queue_op(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
    queue_op(chm_pkg::OP_NOP, 32'h12345678, 32'h87654321);
    queue_op(chm_pkg::OP_REMOVE, 32'h0, 32'h0);
    queue_op(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
    queue_op(chm_pkg::OP_REMOVE, 32'h0, 32'h0);
    queue_op(chm_pkg::OP_REMOVE, 32'h0, 32'h0);
    queue_op(chm_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'h0);
    queue_op(chm_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'h0);
    // Bucket count zero, then one, with a change while entries are held.
    queue_cfg(9'd0);
    queue_op(chm_pkg::OP_INSERT, 32'h11, 32'h5A5A5A5A);
    queue_op(chm_pkg::OP_INSERT, 32'h22, 32'h1);
    queue_op(chm_pkg::OP_LOOKUP, 32'h11, 32'h0);
    queue_cfg(9'd1);
    queue_op(chm_pkg::OP_REMOVE, 32'h11, 32'h0);
    queue_op(chm_pkg::OP_REMOVE, 32'h22, 32'h0);
    queue_cfg(9'h1FF);
    queue_op(chm_pkg::OP_INSERT, 32'h33, 32'h2);
    queue_op(chm_pkg::OP_REMOVE, 32'h33, 32'h0);

    // Random phases; one fills the pool to the full case.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: queue_cfg(9'd256);
        1: queue_cfg(9'd1);
        2: queue_cfg(9'($urandom_range(2, 255)));
        3: queue_cfg(9'd256);
        4: queue_cfg(9'($urandom_range(257, 511)));
        5: queue_cfg(9'd7);
        default: queue_cfg(9'($urandom_range(0, 511)));
      endcase
      keys.delete();
      if (phase == 3) begin
        for (int i = 0; i < 262; i++) begin
          k = $urandom();
          keys.push_back(k);
          queue_op(chm_pkg::OP_INSERT, k, $urandom());
        end
        for (int i = 0; i < 262; i++)
          queue_op($urandom_range(0, 1) ? chm_pkg::OP_REMOVE : chm_pkg::OP_LOOKUP,
                   pick_key(keys), 32'h0);
      end else begin
        for (int i = 0; i < 200; i++) begin
          r = $urandom_range(0, 19);
          if (r < 8) begin
            k = (keys.size() > 0 && r == 0) ? pick_key(keys) : $urandom();
            keys.push_back(k);
            queue_op(chm_pkg::OP_INSERT, k, $urandom());
          end else if (r < 13) queue_op(chm_pkg::OP_LOOKUP, pick_key(keys), $urandom());
          else if (r < 19) queue_op(chm_pkg::OP_REMOVE, pick_key(keys), $urandom());
          else queue_op(chm_pkg::OP_NOP, $urandom(), $urandom());
        end
      end
      // Idling stops once the driver reaches the last phase.
      if (phase == 6) quiet_after = pending_ops.size();
    end
    // Table is left nonempty; back to the reset divisor at the end is not needed.

    wait (pending_ops.size() == 0);
    wait (expected_resps.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_resps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
